// File: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned ExpWidth = 2;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic                in_sequence;
    logic [ExpWidth-1:0] bytes_expected;
    logic [CpWidth-1:0]  partial_value;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               valid_res;
  } dec_result_t;

  localparam dec_state_t StateClear = '{
    in_sequence:    1'b0,
    bytes_expected: '0,
    partial_value:  '0
  };

endpackage

// File: hdl/utf8d_step.sv
`timescale 1ns / 1ps

module utf8d_step (
  input  logic [7:0]             data_byte_i,
  input  logic                   buffer_last_i,
  input  utf8d_pkg::dec_state_t  state_i,
  output utf8d_pkg::dec_state_t  state_o,
  output logic                   has_result_o,
  output utf8d_pkg::dec_result_t result_o
);

  utf8d_pkg::dec_state_t  state_nxt;
  utf8d_pkg::dec_result_t res_nxt;
  logic                   res_vld;
  logic [utf8d_pkg::ExpWidth-1:0] exp_dec;
  logic [utf8d_pkg::CpWidth-1:0]  cont_bits;
  logic [utf8d_pkg::CpWidth-1:0]  part_nxt;

  always_comb begin
    exp_dec = state_i.bytes_expected - 2'd1;
    unique case (exp_dec)
      2'd0:    cont_bits = {15'd0, data_byte_i[5:0]};
      2'd1:    cont_bits = {9'd0, data_byte_i[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, data_byte_i[5:0], 12'd0};
      default: cont_bits = {data_byte_i[2:0], 18'd0};
    endcase
    part_nxt = state_i.partial_value | cont_bits;
  end

  always_comb begin
    state_nxt = utf8d_pkg::StateClear;
    res_vld   = 1'b0;
    res_nxt   = '0;
    priority if (!data_byte_i[7]) begin
      // Seven-bit byte: complete code point, or invalid if it breaks a sequence
      res_vld = 1'b1;
      if (!state_i.in_sequence) begin
        res_nxt.code_point = {13'd0, data_byte_i};
        res_nxt.valid_res  = 1'b1;
      end
    end else if (data_byte_i[6]) begin
      // Lead byte: open a sequence only when none is open
      if (!state_i.in_sequence) begin
        priority if (!data_byte_i[5]) begin
          state_nxt.in_sequence    = 1'b1;
          state_nxt.bytes_expected = 2'd1;
          state_nxt.partial_value  = {10'd0, data_byte_i[4:0], 6'd0};
        end else if (!data_byte_i[4]) begin
          state_nxt.in_sequence    = 1'b1;
          state_nxt.bytes_expected = 2'd2;
          state_nxt.partial_value  = {5'd0, data_byte_i[3:0], 12'd0};
        end else if (!data_byte_i[3]) begin
          state_nxt.in_sequence    = 1'b1;
          state_nxt.bytes_expected = 2'd3;
          state_nxt.partial_value  = {data_byte_i[2:0], 18'd0};
        end else begin
          state_nxt = utf8d_pkg::StateClear;
        end
      end
    end else begin
      // Continuation byte: drop it unless a sequence is waiting for it
      if (state_i.in_sequence && (state_i.bytes_expected != 2'd0)) begin
        if (exp_dec == 2'd0) begin
          res_vld            = 1'b1;
          res_nxt.code_point = part_nxt;
          res_nxt.valid_res  = 1'b1;
        end else begin
          state_nxt.in_sequence    = 1'b1;
          state_nxt.bytes_expected = exp_dec;
          state_nxt.partial_value  = part_nxt;
        end
      end
    end

    if (buffer_last_i) begin
      state_nxt = utf8d_pkg::StateClear;
      if (!res_vld) begin
        res_vld = 1'b1;
        res_nxt = '0;
      end
    end
  end

  assign state_o      = state_nxt;
  assign has_result_o = res_vld;
  assign result_o     = res_nxt;

endmodule

// File: hdl/utf8_to_codepoint_decoder_top.sv
`timescale 1ns / 1ps

// Streaming UTF-8 decoder: one byte per request, with buffer_last_i marking the
// final byte of a buffer. Each accepted byte updates the registered decoder
// state, and a new byte can be accepted every cycle while in_stall_o is low. A
// result goes to the output register, or to the skid register when the output
// register holds a stalled result; this two-entry output lets the input keep
// flowing while one result waits, and in_stall_o rises only once the skid
// register holds a result. Malformed lead or continuation bytes are dropped
// without a result, a seven-bit byte inside a sequence yields an invalid
// result, and a buffer end without a completed result yields an invalid
// result with code point zero. Overlong forms and surrogates pass unchecked.
module utf8_to_codepoint_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        valid_res_o
);

  utf8d_pkg::dec_state_t  state_q, state_d;
  utf8d_pkg::dec_result_t res_d;
  utf8d_pkg::dec_result_t out_q;
  utf8d_pkg::dec_result_t skid_q;
  logic                   has_res;
  logic                   out_valid_q;
  logic                   skid_valid_q;
  logic                   accept;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  utf8d_step u_step (
    .data_byte_i  (data_byte_i),
    .buffer_last_i(buffer_last_i),
    .state_i      (state_q),
    .state_o      (state_d),
    .has_result_o (has_res),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= utf8d_pkg::StateClear;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (!out_stall_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept && has_res) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end else begin
        // hold the stalled result
        out_valid_q <= out_valid_q;
      end
    end
  end

  // Payload registers: load alongside the control above
  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (accept && has_res) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end else begin
      out_q <= out_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_q.code_point;
  assign valid_res_o  = out_q.valid_res;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandItems  = 1600;
  localparam int unsigned CpWidth    = utf8d_pkg::CpWidth;
  localparam int unsigned ExpWidth   = utf8d_pkg::ExpWidth;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        buffer_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [20:0] code_point_o;
  logic        valid_res_o;

  // Decoder state as the scoreboard tracks it
  logic                in_seq;
  logic [ExpWidth-1:0] cont_left;
  logic [CpWidth-1:0]  partial_cp;

  utf8d_pkg::dec_result_t code_point_q[$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          gaps_on;
  stall_mode_e stall_mode;

  utf8_to_codepoint_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .buffer_last_i (buffer_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .valid_res_o   (valid_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2.0) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic predict_code_point(input logic [7:0] b, input logic last);
    utf8d_pkg::dec_result_t res;
    bit          emitted;
    int unsigned ones;
    emitted = 1'b0;
    if (b[7] == 1'b0) begin
      res.code_point = in_seq ? '0 : CpWidth'(b);
      res.valid_res  = ~in_seq;
      emitted        = 1'b1;
      in_seq = 1'b0; cont_left = '0; partial_cp = '0;
    end else if (b[7:6] == 2'b11) begin
      if      (!b[5]) ones = 2;
      else if (!b[4]) ones = 3;
      else if (!b[3]) ones = 4;
      else            ones = 5;
      if (in_seq || ones > 4) begin
        in_seq = 1'b0; cont_left = '0; partial_cp = '0;
      end else begin
        in_seq     = 1'b1;
        cont_left  = ExpWidth'(ones - 1);
        partial_cp = CpWidth'((32'(b) & (32'h7F >> ones)) << (6 * (ones - 1)));
      end
    end else begin
      if (!in_seq || cont_left == 0) begin
        in_seq = 1'b0; cont_left = '0; partial_cp = '0;
      end else begin
        cont_left  = cont_left - 1'b1;
        partial_cp = partial_cp | CpWidth'(32'(b[5:0]) << (6 * cont_left));
        if (cont_left == 0) begin
          res.code_point = partial_cp;
          res.valid_res  = 1'b1;
          emitted        = 1'b1;
          in_seq = 1'b0; partial_cp = '0;
        end
      end
    end
    // Buffer end flushes an unfinished sequence as invalid
    if (last) begin
      if (!emitted) begin
        res.code_point = '0;
        res.valid_res  = 1'b0;
        emitted        = 1'b1;
      end
      in_seq = 1'b0; cont_left = '0; partial_cp = '0;
    end
    if (emitted) code_point_q.push_back(res);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    buffer_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_code_point(b, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (code_point_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // largest value the four-byte form can carry, completed on buffer end
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed();
    send_byte(8'hC3, 1'b0); send_byte(8'hE2, 1'b0);   // lead inside a sequence
    send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);   // five or more leading ones
    send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b0);   // stray continuation
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);                           // ASCII inside a sequence
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b1);   // truncated at buffer end
    send_byte(8'hFE, 1'b1);                           // skipped byte at buffer end
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    logic [7:0]  seq[$];
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    bit          end_buf;
    sent = 0;
    while (sent < n_items) begin
      seq.delete();
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      case (len)
        1: seq.push_back({1'b0, 7'($urandom)});
        2: seq.push_back({3'b110, 5'($urandom)});
        3: seq.push_back({4'b1110, 4'($urandom)});
        default: seq.push_back({5'b11110, 3'($urandom)});
      endcase
      for (int i = 1; i < len; i++) seq.push_back({2'b10, 6'($urandom)});
      if (kind >= 65 && kind < 75 && len > 1) begin
        // drop the tail of the sequence
        cut = $urandom_range(1, len - 1);
        repeat (cut) void'(seq.pop_back());
      end else if (kind >= 75 && kind < 85) begin
        seq.insert($urandom_range(0, seq.size()), 8'($urandom));
      end else if (kind >= 85) begin
        seq.delete();
        repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
      end
      end_buf = ($urandom_range(0, 9) == 0);
      foreach (seq[i]) begin
        send_byte(seq[i], (i == seq.size() - 1 && end_buf) || ($urandom_range(0, 39) == 0));
        sent++;
        if (sent % 150 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  // Receiver stall pattern
  initial begin
    int unsigned phase;
    out_stall_i = 1'b0;
    stall_mode  = StallNone;
    phase       = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase % 150 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        StallNone:     out_stall_i <= 1'b0;
        StallLight:    out_stall_i <= ($urandom_range(0, 99) < 25);
        StallHeavy:    out_stall_i <= ($urandom_range(0, 99) < 75);
        StallPeriodic: out_stall_i <= (phase % 5 < 2);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    utf8d_pkg::dec_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (code_point_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%h ok=%b", code_point_o, valid_res_o));
      end else begin
        want = code_point_q.pop_front();
        if (code_point_o !== want.code_point)
          report_mismatch($sformatf("code_point %h, want %h", code_point_o, want.code_point));
        if (valid_res_o !== want.valid_res)
          report_mismatch($sformatf("valid_res %b, want %b", valid_res_o, want.valid_res));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    buffer_last_i = 1'b0;
    in_seq        = 1'b0;
    cont_left     = '0;
    partial_cp    = '0;
    err_count     = 0;
    cycle_count   = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_ascii();
    gaps_on = 1'b1;
    test_multibyte();
    test_malformed();
    // hold the sender until the block has nothing left in flight
    wait_drain();
    test_random_stream(RandItems);

    in_valid_i <= 1'b0;
    while (code_point_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
